FILE: rtl/lnch_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lnch_pkg
// Shared types, constants and arithmetic for the nearest-centroid histogram.
// ============================================================================
package lnch_pkg;

    localparam int NUM_CENTROIDS = 15;
    localparam int IDX_W         = 4;
    localparam int CNT_W         = 7;
    localparam int PCNT_W        = 6;
    localparam int COMP_W        = 16;
    localparam int PIX_W         = 8;
    localparam int SQ_W          = 2 * COMP_W;
    localparam int DIST_W        = SQ_W + 2;

    localparam logic [CNT_W-1:0]  MAX_CELL   = 7'd64;
    localparam logic [CNT_W-1:0]  MIN_CELL   = 7'd1;
    localparam logic [CNT_W-1:0]  CELL_RESET = 7'd16;
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_CENTROIDS - 1);
    localparam logic [DIST_W-1:0] DIST_INIT  = '1;

    // Word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;

    // One word as it travels down the cell chain
    typedef struct packed {
        logic              vld;
        logic              kind;
        idx_t              entry;
        logic [COMP_W-1:0] cent_l;
        logic [COMP_W-1:0] cent_a;
        logic [COMP_W-1:0] cent_b;
        logic [PIX_W-1:0]  pix_l;
        logic [PIX_W-1:0]  pix_a;
        logic [PIX_W-1:0]  pix_b;
        logic [DIST_W-1:0] best_d;
        idx_t              best_i;
    } item_t;

    // Squared difference of a pixel byte (as 8.8) and an 8.8 component
    function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] p,
                                                 input logic [COMP_W-1:0] c);
        logic [COMP_W-1:0] p16;
        logic [COMP_W-1:0] d;
        logic [SQ_W-1:0]   dw;
        p16 = {p, 8'h00};
        d   = (p16 >= c) ? (p16 - c) : (c - p16);
        // Widen before squaring so the full product is kept
        dw  = SQ_W'(d);
        return dw * dw;
    endfunction

endpackage

FILE: rtl/lnch_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// lnch_cell
// One chain cell: holds one centroid, squares the distance of a passing pixel
// and keeps the nearer of its own and the incoming best match.
// ============================================================================
module lnch_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  lnch_pkg::idx_t  cell_idx,
    input  lnch_pkg::item_t in_item,
    output lnch_pkg::item_t out_item
);

    logic [3*lnch_pkg::COMP_W-1:0] cent_reg;
    lnch_pkg::item_t               mid_reg;
    lnch_pkg::item_t               mid_next;
    lnch_pkg::item_t               out_reg;
    lnch_pkg::item_t               out_next;
    logic [lnch_pkg::SQ_W-1:0]     sq_l_reg;
    logic [lnch_pkg::SQ_W-1:0]     sq_a_reg;
    logic [lnch_pkg::SQ_W-1:0]     sq_b_reg;
    logic [lnch_pkg::DIST_W-1:0]   dist_sum;

    // Capture a centroid load addressed to this cell
    always_ff @(posedge clk)
    begin
        if (adv && in_item.vld && in_item.kind == lnch_pkg::KIND_LOAD &&
            in_item.entry == cell_idx)
        begin
            cent_reg <= {in_item.cent_l, in_item.cent_a, in_item.cent_b};
        end
    end

    // First stage: square the component differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_l_reg <= lnch_pkg::sq_diff(in_item.pix_l,
                                          cent_reg[3*lnch_pkg::COMP_W-1:2*lnch_pkg::COMP_W]);
            sq_a_reg <= lnch_pkg::sq_diff(in_item.pix_a,
                                          cent_reg[2*lnch_pkg::COMP_W-1:lnch_pkg::COMP_W]);
            sq_b_reg <= lnch_pkg::sq_diff(in_item.pix_b,
                                          cent_reg[lnch_pkg::COMP_W-1:0]);
        end
    end

    assign mid_next = in_item;

    // Second stage: sum and keep the strictly nearer match
    always_comb
    begin
        dist_sum = lnch_pkg::DIST_W'(sq_l_reg) + lnch_pkg::DIST_W'(sq_a_reg) +
                   lnch_pkg::DIST_W'(sq_b_reg);
        out_next = mid_reg;
        if (mid_reg.vld && mid_reg.kind == lnch_pkg::KIND_PIXEL &&
            dist_sum < mid_reg.best_d)
        begin
            out_next.best_d = dist_sum;
            out_next.best_i = cell_idx;
        end
    end

    // Advance both stages together with the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
        end
        else if (adv)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule

FILE: rtl/lnch_hist.sv
`timescale 1ns / 1ps
// ============================================================================
// lnch_hist
// Bin counters at the chain tail: counts winning indexes, closes a cell after
// the programmed number of pixels and shifts the histogram out one bin a word.
// ============================================================================
module lnch_hist (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lnch_pkg::item_t            tail,
    input  logic [lnch_pkg::CNT_W-1:0] cell_pixels,
    output logic                       adv,
    output logic                       out_valid,
    input  logic                       out_ready,
    output lnch_pkg::idx_t             bin,
    output logic [lnch_pkg::CNT_W-1:0] count,
    output logic                       last_bin
);

    logic [lnch_pkg::CNT_W-1:0]  bin_reg  [lnch_pkg::NUM_CENTROIDS];
    logic [lnch_pkg::CNT_W-1:0]  bin_next [lnch_pkg::NUM_CENTROIDS];
    logic [lnch_pkg::CNT_W-1:0]  snap_reg [lnch_pkg::NUM_CENTROIDS];
    logic [lnch_pkg::CNT_W-1:0]  snap_next[lnch_pkg::NUM_CENTROIDS];
    logic [lnch_pkg::PCNT_W-1:0] pcnt_reg;
    logic [lnch_pkg::PCNT_W-1:0] pcnt_next;
    lnch_pkg::idx_t              idx_reg;
    lnch_pkg::idx_t              idx_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [lnch_pkg::CNT_W-1:0]  eff_cell;
    logic [lnch_pkg::CNT_W-1:0]  taken;
    logic                        is_pix;
    logic                        close;
    logic                        fire;
    logic                        out_take;

    // Clamp the cell size and test for the end of a cell
    always_comb
    begin
        priority if (cell_pixels == '0)
            eff_cell = lnch_pkg::MIN_CELL;
        else if (cell_pixels > lnch_pkg::MAX_CELL)
            eff_cell = lnch_pkg::MAX_CELL;
        else
            eff_cell = cell_pixels;
    end

    assign taken    = lnch_pkg::CNT_W'(pcnt_reg) + 1'b1;
    assign is_pix   = tail.vld && tail.kind == lnch_pkg::KIND_PIXEL;
    assign close    = taken >= eff_cell;
    // Hold the chain when a closing pixel meets a histogram still draining
    assign adv      = !(is_pix && close && busy_reg);
    assign fire     = adv && is_pix;
    assign out_take = busy_reg && out_ready;

    // Count, snapshot and shift
    always_comb
    begin
        pcnt_next = pcnt_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++)
        begin
            bin_next[k]  = bin_reg[k];
            snap_next[k] = snap_reg[k];
            if (out_take)
            begin
                snap_next[k] = (k + 1 < lnch_pkg::NUM_CENTROIDS) ?
                               snap_reg[(k + 1) % lnch_pkg::NUM_CENTROIDS] : '0;
            end
            if (fire)
            begin
                if (close)
                begin
                    bin_next[k]  = '0;
                    snap_next[k] = bin_reg[k] +
                                   lnch_pkg::CNT_W'(tail.best_i == lnch_pkg::IDX_W'(k));
                end
                else if (tail.best_i == lnch_pkg::IDX_W'(k))
                begin
                    bin_next[k] = bin_reg[k] + 1'b1;
                end
            end
        end
        if (out_take)
        begin
            if (idx_reg == lnch_pkg::LAST_IDX)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
        if (fire)
        begin
            if (close)
            begin
                pcnt_next = '0;
                idx_next  = '0;
                busy_next = 1'b1;
            end
            else
            begin
                pcnt_next = lnch_pkg::PCNT_W'(taken);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            idx_reg  <= '0;
            busy_reg <= 1'b0;
            for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++)
            begin
                bin_reg[k] <= '0;
            end
        end
        else
        begin
            pcnt_reg <= pcnt_next;
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
            for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++)
            begin
                bin_reg[k] <= bin_next[k];
            end
        end
    end

    // Snapshot payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++)
        begin
            snap_reg[k] <= snap_next[k];
        end
    end

    assign out_valid = busy_reg;
    assign bin       = idx_reg;
    assign count     = snap_reg[0];
    assign last_bin  = idx_reg == lnch_pkg::LAST_IDX;

endmodule

FILE: rtl/lab_nearest_centroid_cell_histogram.sv
`timescale 1ns / 1ps
// ============================================================================
// lab_nearest_centroid_cell_histogram
// Nearest-centroid Lab quantizer with a per-cell histogram, built as a chain
// of centroid cells followed by a bin counter and output shifter.
// ============================================================================
// Pipeline: 15 cells, two stages each; a closing pixel's bins are snapshotted.
// Throughput: one word (pixel or load) a cycle unless the chain is held; a
//   closed cell sends 15 bins, one a cycle while out_ready is high, and a pixel
//   that closes the next cell holds the chain at its tail until the cycle after
//   the last bin of the previous histogram is taken.
// Reset: bins and pixel count clear, cell_pixels is 16, centroids unknown.
module lab_nearest_centroid_cell_histogram (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lnch_pkg::CNT_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         kind,
    input  lnch_pkg::idx_t               entry,
    input  logic [lnch_pkg::COMP_W-1:0]  cent_l,
    input  logic [lnch_pkg::COMP_W-1:0]  cent_a,
    input  logic [lnch_pkg::COMP_W-1:0]  cent_b,
    input  logic [lnch_pkg::PIX_W-1:0]   pix_l,
    input  logic [lnch_pkg::PIX_W-1:0]   pix_a,
    input  logic [lnch_pkg::PIX_W-1:0]   pix_b,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lnch_pkg::idx_t               bin,
    output logic [lnch_pkg::CNT_W-1:0]   count,
    output logic                         last_bin
);

    lnch_pkg::item_t            link [lnch_pkg::NUM_CENTROIDS + 1];
    logic [lnch_pkg::CNT_W-1:0] cell_pixels_reg;
    logic                       adv;

    // Cell size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_pixels_reg <= lnch_pkg::CELL_RESET;
        else if (cfg_valid)
            cell_pixels_reg <= cfg_data;
    end

    // Feed the chain head
    always_comb
    begin
        link[0]        = '0;
        link[0].vld    = in_valid;
        link[0].kind   = kind;
        link[0].entry  = entry;
        link[0].cent_l = cent_l;
        link[0].cent_a = cent_a;
        link[0].cent_b = cent_b;
        link[0].pix_l  = pix_l;
        link[0].pix_a  = pix_a;
        link[0].pix_b  = pix_b;
        link[0].best_d = lnch_pkg::DIST_INIT;
        link[0].best_i = '0;
    end

    assign in_ready = adv;

    // Centroid cells
    for (genvar g = 0; g < lnch_pkg::NUM_CENTROIDS; g++)
    begin : g_cell
        lnch_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_idx (lnch_pkg::IDX_W'(g)),
            .in_item  (link[g]),
            .out_item (link[g + 1])
        );
    end

    // Histogram at the chain tail
    lnch_hist u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .tail        (link[lnch_pkg::NUM_CENTROIDS]),
        .cell_pixels (cell_pixels_reg),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bin         (bin),
        .count       (count),
        .last_bin    (last_bin)
    );

    // The chain only stalls behind a histogram that is still draining
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with no histogram pending");

    // A histogram always starts at bin zero
    a_first_bin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> bin == '0)
        else $error("histogram did not start at bin zero");

    // Taking the last bin leaves the output empty
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_bin |=> !out_valid)
        else $error("output still valid after last bin");

endmodule

FILE: tb/sv/tb_lab_nearest_centroid_cell_histogram.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_lab_nearest_centroid_cell_histogram
// Self-checking bench for the nearest-centroid Lab cell histogram. Loads the
// centroid store, streams pixels through several cell sizes and idle/stall
// patterns, predicts each cell's histogram on its own and compares every bin
// word that comes out, field by field, in order.
// ============================================================================
module tb_lab_nearest_centroid_cell_histogram;

    localparam int CHAIN_SETTLE = 48;    // chain depth plus output slack
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving

    // One input word
    typedef struct packed {
        logic                        kind;
        lnch_pkg::idx_t              entry;
        logic [lnch_pkg::COMP_W-1:0] cent_l;
        logic [lnch_pkg::COMP_W-1:0] cent_a;
        logic [lnch_pkg::COMP_W-1:0] cent_b;
        logic [lnch_pkg::PIX_W-1:0]  pix_l;
        logic [lnch_pkg::PIX_W-1:0]  pix_a;
        logic [lnch_pkg::PIX_W-1:0]  pix_b;
    } lab_word_t;

    // One histogram bin word
    typedef struct packed {
        lnch_pkg::idx_t             bin_idx;
        logic [lnch_pkg::CNT_W-1:0] pixels;
        logic                       is_last;
    } bin_word_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [lnch_pkg::CNT_W-1:0]  cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic                        kind      = lnch_pkg::KIND_PIXEL;
    lnch_pkg::idx_t              entry     = '0;
    logic [lnch_pkg::COMP_W-1:0] cent_l    = '0;
    logic [lnch_pkg::COMP_W-1:0] cent_a    = '0;
    logic [lnch_pkg::COMP_W-1:0] cent_b    = '0;
    logic [lnch_pkg::PIX_W-1:0]  pix_l     = '0;
    logic [lnch_pkg::PIX_W-1:0]  pix_a     = '0;
    logic [lnch_pkg::PIX_W-1:0]  pix_b     = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    lnch_pkg::idx_t              bin;
    logic [lnch_pkg::CNT_W-1:0]  count;
    logic                        last_bin;

    // Predictor state
    logic [lnch_pkg::COMP_W-1:0] centroids [lnch_pkg::NUM_CENTROIDS][3];
    logic [lnch_pkg::CNT_W-1:0]  bin_tally [lnch_pkg::NUM_CENTROIDS];
    int unsigned                 pixels_taken    = 0;
    logic [lnch_pkg::CNT_W-1:0]  cfg_cell_pixels = lnch_pkg::CELL_RESET;
    bin_word_t                   hist_expected [$];
    bin_word_t                   want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    lab_nearest_centroid_cell_histogram i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .entry     (entry),
        .cent_l    (cent_l),
        .cent_a    (cent_a),
        .cent_b    (cent_b),
        .pix_l     (pix_l),
        .pix_a     (pix_a),
        .pix_b     (pix_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .bin       (bin),
        .count     (count),
        .last_bin  (last_bin)
    );

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Histogram predictor
    // ------------------------------------------------------------------

    // Squared error of one component, pixel byte taken as 8.8
    function automatic longint unsigned comp_err2(
        input logic [lnch_pkg::PIX_W-1:0]  p,
        input logic [lnch_pkg::COMP_W-1:0] c);
        longint unsigned p88;
        longint unsigned d;
        p88 = longint'(p) * 256;
        d   = (p88 >= longint'(c)) ? p88 - longint'(c) : longint'(c) - p88;
        return d * d;
    endfunction

    // Apply one accepted word and queue any bins it closes
    function automatic void quantize_word(input lab_word_t w);
        longint unsigned sq_dist;
        longint unsigned best;
        lnch_pkg::idx_t  best_i;
        int unsigned     cell_len;
        bin_word_t       b;
        if (w.kind == lnch_pkg::KIND_LOAD) begin
            if (w.entry < lnch_pkg::idx_t'(lnch_pkg::NUM_CENTROIDS)) begin
                centroids[w.entry][0] = w.cent_l;
                centroids[w.entry][1] = w.cent_a;
                centroids[w.entry][2] = w.cent_b;
            end
            return;
        end
        best   = 0;
        best_i = '0;
        for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++) begin
            sq_dist = comp_err2(w.pix_l, centroids[k][0])
                    + comp_err2(w.pix_a, centroids[k][1])
                    + comp_err2(w.pix_b, centroids[k][2]);
            if (k == 0 || sq_dist < best) begin
                best   = sq_dist;
                best_i = lnch_pkg::idx_t'(k);
            end
        end
        if (bin_tally[best_i] != '1)
            bin_tally[best_i] = bin_tally[best_i] + 1'b1;
        // Clamp the cell size the way the block does
        if (cfg_cell_pixels == '0)
            cell_len = 1;
        else if (cfg_cell_pixels > lnch_pkg::MAX_CELL)
            cell_len = 32'(lnch_pkg::MAX_CELL);
        else
            cell_len = 32'(cfg_cell_pixels);
        pixels_taken++;
        if (pixels_taken >= cell_len) begin
            for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++) begin
                b.bin_idx = lnch_pkg::idx_t'(k);
                b.pixels  = bin_tally[k];
                b.is_last = (k == lnch_pkg::NUM_CENTROIDS - 1);
                hist_expected = {hist_expected, b};
                bin_tally[k] = '0;
            end
            pixels_taken = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------

    // Send one word; valid stays high on return so back-to-back words flow
    task automatic send_word(input lab_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= w.kind;
        entry    <= w.entry;
        cent_l   <= w.cent_l;
        cent_a   <= w.cent_a;
        cent_b   <= w.cent_b;
        pix_l    <= w.pix_l;
        pix_a    <= w.pix_a;
        pix_b    <= w.pix_b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        quantize_word(w);
    endtask

    // Hold the input and wait for every queued bin
    task automatic await_histograms();
        in_valid <= 1'b0;
        while (hist_expected.size() != 0)
            @(posedge clk);
    endtask

    // Hold the input until the chain is empty
    task automatic drain_block();
        await_histograms();
        repeat (CHAIN_SETTLE)
            @(posedge clk);
    endtask

    task automatic write_cell_size(input logic [lnch_pkg::CNT_W-1:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_cell_pixels = n;
    endtask

    function automatic lab_word_t make_word(input logic k, input lnch_pkg::idx_t e,
                                            input logic [lnch_pkg::COMP_W-1:0] l,
                                            input logic [lnch_pkg::COMP_W-1:0] a,
                                            input logic [lnch_pkg::COMP_W-1:0] b,
                                            input logic [lnch_pkg::PIX_W-1:0] pl,
                                            input logic [lnch_pkg::PIX_W-1:0] pa,
                                            input logic [lnch_pkg::PIX_W-1:0] pb);
        lab_word_t w;
        w = '{k, e, l, a, b, pl, pa, pb};
        return w;
    endfunction

    // Pixel word with random bytes
    function automatic lab_word_t random_pixel();
        return make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0,
                         lnch_pkg::PIX_W'($urandom), lnch_pkg::PIX_W'($urandom),
                         lnch_pkg::PIX_W'($urandom));
    endfunction

    // Mostly pixels, some from a stored centroid's upper bytes; a few reloads
    function automatic lab_word_t random_word();
        lab_word_t w;
        int        pick;
        w.kind   = ($urandom_range(99) < 10) ? lnch_pkg::KIND_LOAD : lnch_pkg::KIND_PIXEL;
        w.entry  = lnch_pkg::idx_t'($urandom_range(15));
        w.cent_l = lnch_pkg::COMP_W'($urandom);
        w.cent_a = lnch_pkg::COMP_W'($urandom);
        w.cent_b = lnch_pkg::COMP_W'($urandom);
        w.pix_l  = lnch_pkg::PIX_W'($urandom);
        w.pix_a  = lnch_pkg::PIX_W'($urandom);
        w.pix_b  = lnch_pkg::PIX_W'($urandom);
        if ($urandom_range(2) == 0) begin
            pick    = $urandom_range(lnch_pkg::NUM_CENTROIDS - 1);
            w.pix_l = centroids[pick][0][15:8];
            w.pix_a = centroids[pick][1][15:8];
            w.pix_b = centroids[pick][2][15:8];
        end
        return w;
    endfunction

    // Stream random words, optionally pausing once for all bins to return
    task automatic stream_words(input int n, input int pause_at);
        for (int i = 0; i < n; i++) begin
            if (i == pause_at)
                await_histograms();
            send_word(random_word());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill every entry; entry 5 and 6 match to force a tie; entry 15 is dropped
    task automatic test_centroid_load();
        logic [lnch_pkg::COMP_W-1:0] l, a, b;
        for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++) begin
            l = lnch_pkg::COMP_W'(k * 4681);
            a = lnch_pkg::COMP_W'(65535 - k * 4681);
            b = lnch_pkg::COMP_W'(k * 9973);
            if (k == 0) begin
                l = '0; a = '0; b = '0;
            end
            if (k == 6) begin
                l = lnch_pkg::COMP_W'(5 * 4681);
                a = lnch_pkg::COMP_W'(65535 - 5 * 4681);
                b = lnch_pkg::COMP_W'(5 * 9973);
            end
            if (k == lnch_pkg::NUM_CENTROIDS - 1) begin
                l = '1; a = '1; b = '1;
            end
            send_word(make_word(lnch_pkg::KIND_LOAD, lnch_pkg::idx_t'(k), l, a, b,
                                8'h00, 8'h00, 8'h00));
        end
        send_word(make_word(lnch_pkg::KIND_LOAD, 4'hF, 16'h8000, 16'h8000, 16'h8000,
                            8'hFF, 8'hFF, 8'hFF));
    endtask

    // Corners of the pixel space, the tie and the pixel near the dropped load
    task automatic test_extreme_pixels();
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'hF, '1, '1, '1, 8'h00, 8'h00, 8'h00));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'hFF, 8'h00, 8'hFF));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'h00, 8'hFF, 8'h00));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0,
                            centroids[5][0][15:8], centroids[5][1][15:8],
                            centroids[5][2][15:8]));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'h80, 8'h80, 8'h80));
    endtask

    // Close cells at the size that reset leaves
    task automatic test_reset_cell_size();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stream_words(12, -1);
    endtask

    // Shrink the cell below the pixels already taken, then use size zero
    task automatic test_cell_shrink_mid_cell();
        drain_block();
        write_cell_size(lnch_pkg::MAX_CELL);
        for (int i = 0; i < 3; i++)
            send_word(random_pixel());
        drain_block();
        write_cell_size(7'd3);
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'h40, 8'hC0, 8'h20));
        drain_block();
        write_cell_size(7'd0);
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'h10, 8'h20, 8'h30));
        send_word(make_word(lnch_pkg::KIND_PIXEL, 4'h0, '0, '0, '0, 8'hE0, 8'h70, 8'hF0));
    endtask

    task automatic test_single_pixel_cells();
        drain_block();
        write_cell_size(lnch_pkg::MIN_CELL);
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        stream_words(6, -1);
    endtask

    task automatic test_receiver_stall();
        drain_block();
        write_cell_size(7'd7);
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        stream_words(12, 9);
    endtask

    // Oversize setting clamps to the largest cell
    task automatic test_oversize_cells();
        drain_block();
        write_cell_size(7'd127);
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        for (int i = 0; i < 64; i++)
            send_word(random_pixel());
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Compare each bin word against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            if (hist_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected bin %0d count %0d last %0b",
                                          bin, count, last_bin));
            end else begin
                want = hist_expected.pop_front();
                if (bin !== want.bin_idx || count !== want.pixels
                        || last_bin !== want.is_last)
                    report_mismatch($sformatf(
                        "got bin %0d count %0d last %0b, want bin %0d count %0d last %0b",
                        bin, count, last_bin, want.bin_idx, want.pixels, want.is_last));
            end
        end
    end

    // Randomize the receiver's readiness
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when no word moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_lab_nearest_centroid_cell_histogram NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < lnch_pkg::NUM_CENTROIDS; k++) begin
            centroids[k] = '{'0, '0, '0};
            bin_tally[k] = '0;
        end
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_centroid_load();
        test_extreme_pixels();
        test_reset_cell_size();
        test_cell_shrink_mid_cell();
        test_single_pixel_cells();
        test_receiver_stall();
        test_oversize_cells();
        drain_block();

        if (mismatches == 0)
            $display("tb_lab_nearest_centroid_cell_histogram OK");
        else
            $display("tb_lab_nearest_centroid_cell_histogram NOT OK");
        $finish;
    end

endmodule
